// ===== rtl/tfcr_pkg.sv =====
// ============================================================================
// tfcr_pkg: shared types and constants of the feedback comb resonator
// Holds the sizes, register codes, state encodings and the control
// structures that pass between the sequencer, the tuning unit and the lanes.
// ============================================================================
`default_nettype none

package tfcr_pkg;

    // Delay memory and sample format.
    localparam int MAX_DELAY   = 16384;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(MAX_DELAY);
    localparam int FRAC_W      = 8;
    localparam int HELD_W      = ADDR_W + FRAC_W;

    // Stream word: two samples, padded to whole bytes.
    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Configuration register widths.
    localparam int SR_W       = 18;
    localparam int BASE_W     = 15;
    localparam int NORM_W     = 16;
    localparam int STR_W      = 16;
    localparam int FB_W       = 16;
    localparam int STEP_W     = 16;
    localparam int MOD_W      = 3;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    // Register reset values.
    localparam logic [SR_W-1:0]   SR_RESET   = SR_W'(48000);
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(440);
    localparam logic [NORM_W-1:0] NORM_RESET = NORM_W'(32768);

    // Delay that the reset register values produce: 48000 * 2^24 / (440 * 2^16).
    localparam logic [HELD_W-1:0] HELD_RESET = HELD_W'(27927);

    // Modulation enable bits.
    localparam int MOD_OFFSET   = 0;
    localparam int MOD_FEEDBACK = 1;
    localparam int MOD_STRENGTH = 2;

    // Q16 arithmetic.
    localparam int Q16_SHIFT = 16;
    localparam logic [NORM_W:0] UNITY_Q16 = (NORM_W + 1)'(65536);
    localparam logic [FB_W:0]   FB_LIMIT  = (FB_W + 1)'(62259);

    // Detune and frequency path widths.
    localparam int NORM2_W = NORM_W + 3;
    localparam int P1_W    = 34;
    localparam int P2_W    = 43;
    localparam int DET_W   = P2_W - Q16_SHIFT;
    localparam int F_W     = 35;
    localparam int DIV_W   = 32;
    localparam int QUO_W   = 24;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic signed [NORM2_W-1:0] NORM2_BIAS = NORM2_W'(65536);
    localparam logic signed [10:0]        DETUNE_HZ  = 11'sd1000;
    localparam logic [P2_W-1:0]           P2_ROUND   = P2_W'(65535);
    localparam logic signed [F_W-1:0]     F_UNITY    = F_W'(65536);
    localparam logic signed [F_W-1:0]     F_LOW      = F_W'(20 * 65536);
    localparam logic [QUO_W-1:0]          HELD_MIN_Q = QUO_W'(256);
    localparam logic [QUO_W-1:0]          HELD_MAX_Q = QUO_W'(MAX_DELAY * 256 - 1);

    // Lane datapath widths.
    localparam int ACC_W  = SAMPLE_BITS + FRAC_W + 2;
    localparam int PROD_W = SAMPLE_BITS + FB_W + 1;
    localparam int TERM_W = PROD_W - Q16_SHIFT;
    localparam int SUM_W  = SAMPLE_BITS + 2;

    localparam logic [ACC_W-1:0]  INTERP_ROUND = ACC_W'((1 << FRAC_W) - 1);
    localparam logic [PROD_W-1:0] FB_ROUND     = PROD_W'(65535);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE     = 3'd0,
        REG_BASE_FREQ       = 3'd1,
        REG_OFFSET_NORM     = 3'd2,
        REG_OFFSET_STRENGTH = 3'd3,
        REG_FEEDBACK_GAIN   = 3'd4,
        REG_STEP_VALUE      = 3'd5,
        REG_MOD_ENABLES     = 3'd6
    } cfg_reg_t;

    // Tuning unit states.
    typedef enum logic [2:0] {
        T_IDLE,
        T_MUL1,
        T_MUL2,
        T_FREQ,
        T_DIV
    } tune_state_t;

    // Sample sequencer states.
    typedef enum logic [2:0] {
        C_CLEAR,
        C_IDLE,
        C_INTERP,
        C_MULT,
        C_DONE
    } ctrl_state_t;

    // Tuning results handed to the sequencer.
    typedef struct packed {
        logic              busy;
        logic [HELD_W-1:0] held_delay;
        logic [FB_W-1:0]   fb_eff;
    } tune_t;

    // Per-cycle commands from the sequencer to both lanes.
    typedef struct packed {
        logic              rd_en;
        logic              interp_en;
        logic              mult_en;
        logic              wr_en;
        logic              wr_zero;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic [FRAC_W-1:0] frac;
        logic [FB_W-1:0]   fb;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tfcr_tune.sv =====
// ============================================================================
// tfcr_tune: configuration registers and delay tuning
// Holds the registers, forms the modulated feedback gain, and after every
// register write works out the fractional delay sample_rate / frequency
// with two multiplies, a clamp and a bit-per-cycle restoring divider.
// ============================================================================
`default_nettype none

module tfcr_tune (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [tfcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tfcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output      tfcr_pkg::tune_t                  tune
);

    // Configuration registers.
    logic [tfcr_pkg::SR_W-1:0]   sr_reg;
    logic [tfcr_pkg::BASE_W-1:0] base_reg;
    logic [tfcr_pkg::NORM_W-1:0] norm_reg;
    logic [tfcr_pkg::STR_W-1:0]  str_reg;
    logic [tfcr_pkg::FB_W-1:0]   fb_reg;
    logic [tfcr_pkg::STEP_W-1:0] step_reg;
    logic [tfcr_pkg::MOD_W-1:0]  mod_reg;

    tfcr_pkg::tune_state_t state_reg, state_next;

    logic cfg_fire;
    logic busy;

    // Modulated values.
    logic [tfcr_pkg::NORM_W:0] norm_sum, norm_m;
    logic [tfcr_pkg::STR_W:0]  str_sum, str_m;
    logic [tfcr_pkg::FB_W:0]   fb_sum, fb_pre;
    logic [tfcr_pkg::FB_W-1:0] fb_eff;

    // Detune and frequency path.
    logic signed [tfcr_pkg::NORM2_W-1:0] norm2;
    logic signed [tfcr_pkg::STR_W+1:0]   str_s;
    logic signed [tfcr_pkg::P1_W-1:0]    p1_next, p1_reg;
    logic signed [tfcr_pkg::P2_W-1:0]    p2_next, p2_reg;
    logic [tfcr_pkg::P2_W-1:0]           p2_adj;
    logic signed [tfcr_pkg::DET_W-1:0]   detune;
    logic signed [tfcr_pkg::F_W-1:0]     f_raw, f_hi, f_upper, f_clamped;

    // Divider.
    logic [tfcr_pkg::DIV_W-1:0]     f_reg;
    logic [tfcr_pkg::DIV_W:0]       rem_reg, rem_next, trial;
    logic [tfcr_pkg::QUO_W-1:0]     quo_reg, quo_next, quo_clamped;
    logic [tfcr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           trial_ge;
    logic                           div_last;
    logic [tfcr_pkg::HELD_W-1:0]    held_reg;

    assign cfg_fire = cfg_valid && cfg_ready;

    // Register writes; an unknown index is accepted and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_reg   <= tfcr_pkg::SR_RESET;
            base_reg <= tfcr_pkg::BASE_RESET;
            norm_reg <= tfcr_pkg::NORM_RESET;
            str_reg  <= '0;
            fb_reg   <= '0;
            step_reg <= '0;
            mod_reg  <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                tfcr_pkg::REG_SAMPLE_RATE:     sr_reg   <= cfg_data[tfcr_pkg::SR_W-1:0];
                tfcr_pkg::REG_BASE_FREQ:       base_reg <= cfg_data[tfcr_pkg::BASE_W-1:0];
                tfcr_pkg::REG_OFFSET_NORM:     norm_reg <= cfg_data[tfcr_pkg::NORM_W-1:0];
                tfcr_pkg::REG_OFFSET_STRENGTH: str_reg  <= cfg_data[tfcr_pkg::STR_W-1:0];
                tfcr_pkg::REG_FEEDBACK_GAIN:   fb_reg   <= cfg_data[tfcr_pkg::FB_W-1:0];
                tfcr_pkg::REG_STEP_VALUE:      step_reg <= cfg_data[tfcr_pkg::STEP_W-1:0];
                tfcr_pkg::REG_MOD_ENABLES:     mod_reg  <= cfg_data[tfcr_pkg::MOD_W-1:0];
                default:                       ;
            endcase
        end
    end

    // Step modulation with saturation at unity, feedback capped at 0.95.
    always_comb
    begin
        norm_sum = {1'b0, norm_reg} + (tfcr_pkg::NORM_W + 1)'(step_reg);
        str_sum  = {1'b0, str_reg} + (tfcr_pkg::STR_W + 1)'(step_reg);
        fb_sum   = {1'b0, fb_reg} + (tfcr_pkg::FB_W + 1)'(step_reg);

        if (mod_reg[tfcr_pkg::MOD_OFFSET])
            norm_m = (norm_sum > tfcr_pkg::UNITY_Q16) ? tfcr_pkg::UNITY_Q16 : norm_sum;
        else
            norm_m = {1'b0, norm_reg};

        if (mod_reg[tfcr_pkg::MOD_STRENGTH])
            str_m = (str_sum > tfcr_pkg::UNITY_Q16) ? tfcr_pkg::UNITY_Q16 : str_sum;
        else
            str_m = {1'b0, str_reg};

        fb_pre = mod_reg[tfcr_pkg::MOD_FEEDBACK] ? fb_sum : {1'b0, fb_reg};
        fb_eff = (fb_pre > tfcr_pkg::FB_LIMIT) ? tfcr_pkg::FB_LIMIT[tfcr_pkg::FB_W-1:0]
                                               : fb_pre[tfcr_pkg::FB_W-1:0];
    end

    // Detune product (2*norm - 1) * strength, then times 1000 Hz.
    assign norm2   = $signed({1'b0, norm_m, 1'b0}) - tfcr_pkg::NORM2_BIAS;
    assign str_s   = $signed({1'b0, str_m});
    assign p1_next = norm2 * str_s;
    assign p2_next = p1_reg * tfcr_pkg::DETUNE_HZ;

    // Scale the detune to Q16 Hz toward zero and clamp the frequency.
    always_comb
    begin
        p2_adj  = p2_reg + (p2_reg[tfcr_pkg::P2_W-1] ? tfcr_pkg::P2_ROUND : '0);
        detune  = $signed(p2_adj[tfcr_pkg::P2_W-1:tfcr_pkg::Q16_SHIFT]);
        f_raw   = $signed({{(tfcr_pkg::F_W - tfcr_pkg::BASE_W - tfcr_pkg::Q16_SHIFT){1'b0}},
                           base_reg, {tfcr_pkg::Q16_SHIFT{1'b0}}})
                + tfcr_pkg::F_W'(detune);
        f_hi    = $signed({{(tfcr_pkg::F_W - tfcr_pkg::SR_W - tfcr_pkg::Q16_SHIFT + 1){1'b0}},
                           sr_reg, {(tfcr_pkg::Q16_SHIFT - 1){1'b0}}})
                - tfcr_pkg::F_UNITY;
        f_upper   = (f_raw > f_hi) ? f_hi : f_raw;
        f_clamped = (f_upper < tfcr_pkg::F_LOW) ? tfcr_pkg::F_LOW : f_upper;
    end

    // One quotient bit per cycle, then the delay is saturated to the memory.
    always_comb
    begin
        trial       = {rem_reg[tfcr_pkg::DIV_W-1:0], 1'b0};
        trial_ge    = trial >= {1'b0, f_reg};
        rem_next    = trial_ge ? (trial - {1'b0, f_reg}) : trial;
        quo_next    = {quo_reg[tfcr_pkg::QUO_W-2:0], trial_ge};
        div_last    = cnt_reg == tfcr_pkg::DIV_CNT_W'(tfcr_pkg::QUO_W - 1);
        if (quo_next < tfcr_pkg::HELD_MIN_Q)
            quo_clamped = tfcr_pkg::HELD_MIN_Q;
        else if (quo_next > tfcr_pkg::HELD_MAX_Q)
            quo_clamped = tfcr_pkg::HELD_MAX_Q;
        else
            quo_clamped = quo_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfcr_pkg::T_IDLE: if (cfg_fire) state_next = tfcr_pkg::T_MUL1;
            tfcr_pkg::T_MUL1: state_next = tfcr_pkg::T_MUL2;
            tfcr_pkg::T_MUL2: state_next = tfcr_pkg::T_FREQ;
            tfcr_pkg::T_FREQ: state_next = tfcr_pkg::T_DIV;
            tfcr_pkg::T_DIV:  if (div_last) state_next = tfcr_pkg::T_IDLE;
            default:          state_next = tfcr_pkg::T_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        cfg_ready = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            tfcr_pkg::T_IDLE:
            begin
                cfg_ready = 1'b1;
                busy      = 1'b0;
            end
            default:
            begin
                cfg_ready = 1'b0;
                busy      = 1'b1;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfcr_pkg::T_IDLE;
            cnt_reg   <= '0;
            held_reg  <= tfcr_pkg::HELD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tfcr_pkg::T_FREQ)
                cnt_reg <= '0;
            else if (state_reg == tfcr_pkg::T_DIV)
                cnt_reg <= cnt_reg + tfcr_pkg::DIV_CNT_W'(1);
            if (state_reg == tfcr_pkg::T_DIV && div_last)
                held_reg <= quo_clamped[tfcr_pkg::HELD_W-1:0];
        end
    end

    // Arithmetic pipeline registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tfcr_pkg::T_MUL1: p1_reg <= p1_next;
            tfcr_pkg::T_MUL2: p2_reg <= p2_next;
            tfcr_pkg::T_FREQ:
            begin
                f_reg   <= f_clamped[tfcr_pkg::DIV_W-1:0];
                rem_reg <= (tfcr_pkg::DIV_W + 1)'(sr_reg);
                quo_reg <= '0;
            end
            tfcr_pkg::T_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            default: ;
        endcase
    end

    assign tune.busy       = busy;
    assign tune.held_delay = held_reg;
    assign tune.fb_eff     = fb_eff;

endmodule

`default_nettype wire

// ===== rtl/tfcr_lane.sv =====
// ============================================================================
// tfcr_lane: one channel of the comb resonator
// Owns the channel's delay memory, reads the two taps around the fractional
// delay, interpolates, applies the feedback gain and saturates the sum.
// ============================================================================
`default_nettype none

module tfcr_lane (
    input  wire logic                                     clk,
    input  wire tfcr_pkg::lane_ctrl_t                     ctrl,
    input  wire logic signed [tfcr_pkg::SAMPLE_BITS-1:0]  sample,
    output      logic signed [tfcr_pkg::SAMPLE_BITS-1:0]  result
);

    logic signed [tfcr_pkg::SAMPLE_BITS-1:0] mem [tfcr_pkg::MAX_DELAY];

    logic signed [tfcr_pkg::SAMPLE_BITS-1:0] tap_a_reg, tap_b_reg, sample_reg;
    logic signed [tfcr_pkg::SAMPLE_BITS-1:0] wr_data;
    logic signed [tfcr_pkg::SAMPLE_BITS:0]   diff;
    logic signed [tfcr_pkg::ACC_W-1:0]       frac_prod, acc;
    logic [tfcr_pkg::ACC_W-1:0]              acc_adj;
    logic signed [tfcr_pkg::SAMPLE_BITS-1:0] delayed_next, delayed_reg;
    logic signed [tfcr_pkg::PROD_W-1:0]      fb_prod, fb_prod_reg;
    logic [tfcr_pkg::PROD_W-1:0]             fb_adj;
    logic signed [tfcr_pkg::TERM_W-1:0]      fb_term;
    logic signed [tfcr_pkg::SUM_W-1:0]       sum;

    // Delay memory: one write port, two registered read ports.
    assign wr_data = ctrl.wr_zero ? '0 : result;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[ctrl.wr_addr] <= wr_data;
        if (ctrl.rd_en)
        begin
            tap_a_reg <= mem[ctrl.rd_addr_a];
            tap_b_reg <= mem[ctrl.rd_addr_b];
        end
    end

    // Hold the incoming sample for the final sum.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
            sample_reg <= sample;
    end

    // Linear interpolation a + (b - a) * r / 256, rounded toward zero.
    always_comb
    begin
        diff         = tap_b_reg - tap_a_reg;
        frac_prod    = diff * $signed({1'b0, ctrl.frac});
        acc          = (tfcr_pkg::ACC_W'(tap_a_reg) <<< tfcr_pkg::FRAC_W) + frac_prod;
        acc_adj      = acc + (acc[tfcr_pkg::ACC_W-1] ? tfcr_pkg::INTERP_ROUND : '0);
        delayed_next = $signed(acc_adj[tfcr_pkg::FRAC_W+tfcr_pkg::SAMPLE_BITS-1:
                                       tfcr_pkg::FRAC_W]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.interp_en)
            delayed_reg <= delayed_next;
    end

    // Feedback gain product.
    assign fb_prod = delayed_reg * $signed({1'b0, ctrl.fb});

    always_ff @(posedge clk)
    begin
        if (ctrl.mult_en)
            fb_prod_reg <= fb_prod;
    end

    // Scale toward zero, add the input and saturate.
    always_comb
    begin
        fb_adj  = fb_prod_reg + (fb_prod_reg[tfcr_pkg::PROD_W-1] ? tfcr_pkg::FB_ROUND : '0);
        fb_term = $signed(fb_adj[tfcr_pkg::PROD_W-1:tfcr_pkg::Q16_SHIFT]);
        sum     = tfcr_pkg::SUM_W'(sample_reg) + tfcr_pkg::SUM_W'(fb_term);
        if (sum > tfcr_pkg::SAT_MAX)
            result = tfcr_pkg::SAT_MAX[tfcr_pkg::SAMPLE_BITS-1:0];
        else if (sum < tfcr_pkg::SAT_MIN)
            result = tfcr_pkg::SAT_MIN[tfcr_pkg::SAMPLE_BITS-1:0];
        else
            result = sum[tfcr_pkg::SAMPLE_BITS-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/tfcr_ctrl.sv =====
// ============================================================================
// tfcr_ctrl: sample sequencer
// Clears the delay memories after reset, then steps each accepted word
// through read, interpolate, multiply and commit, and keeps the write pointer.
// ============================================================================
`default_nettype none

module tfcr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire tfcr_pkg::tune_t      tune,
    input  wire logic                 out_free,
    output      logic                 commit,
    output      tfcr_pkg::lane_ctrl_t lane_ctrl
);

    tfcr_pkg::ctrl_state_t state_reg, state_next;

    logic [tfcr_pkg::ADDR_W-1:0] wp_reg;
    logic [tfcr_pkg::ADDR_W-1:0] clr_reg;
    logic [tfcr_pkg::ADDR_W-1:0] tap_n;
    logic [tfcr_pkg::ADDR_W-1:0] addr_a;
    logic                        clearing;
    logic                        clr_last;
    logic                        accept;

    assign clr_last = &clr_reg;
    assign accept   = s_tvalid && s_tready;

    // Tap addresses: n and n+1 samples behind the write pointer.
    assign tap_n  = tune.held_delay[tfcr_pkg::HELD_W-1:tfcr_pkg::FRAC_W];
    assign addr_a = wp_reg - tap_n;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfcr_pkg::C_CLEAR:  if (clr_last) state_next = tfcr_pkg::C_IDLE;
            tfcr_pkg::C_IDLE:   if (accept) state_next = tfcr_pkg::C_INTERP;
            tfcr_pkg::C_INTERP: state_next = tfcr_pkg::C_MULT;
            tfcr_pkg::C_MULT:   state_next = tfcr_pkg::C_DONE;
            tfcr_pkg::C_DONE:   if (out_free) state_next = tfcr_pkg::C_IDLE;
            default:            state_next = tfcr_pkg::C_CLEAR;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        s_tready = 1'b0;
        clearing = 1'b0;
        commit   = 1'b0;
        lane_ctrl.interp_en = 1'b0;
        lane_ctrl.mult_en   = 1'b0;
        case (state_reg)
            tfcr_pkg::C_CLEAR:  clearing = 1'b1;
            tfcr_pkg::C_IDLE:   s_tready = !tune.busy;
            tfcr_pkg::C_INTERP: lane_ctrl.interp_en = 1'b1;
            tfcr_pkg::C_MULT:   lane_ctrl.mult_en = 1'b1;
            tfcr_pkg::C_DONE:   commit = out_free;
            default:            ;
        endcase
        lane_ctrl.rd_en     = s_tvalid && s_tready;
        lane_ctrl.wr_en     = commit || clearing;
        lane_ctrl.wr_zero   = clearing;
        lane_ctrl.wr_addr   = clearing ? clr_reg : wp_reg;
        lane_ctrl.rd_addr_a = addr_a;
        lane_ctrl.rd_addr_b = addr_a - tfcr_pkg::ADDR_W'(1);
        lane_ctrl.frac      = tune.held_delay[tfcr_pkg::FRAC_W-1:0];
        lane_ctrl.fb        = tune.fb_eff;
    end

    // State, write pointer and clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfcr_pkg::C_CLEAR;
            wp_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + tfcr_pkg::ADDR_W'(1);
            if (commit)
                wp_reg <= wp_reg + tfcr_pkg::ADDR_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tunable_feedback_comb_resonator.sv =====
// ============================================================================
// tunable_feedback_comb_resonator: stereo feedback comb resonator
// Top level: tuning unit, sequencer, two channel lanes and the output stage.
// ============================================================================
// Usage:
// s_tdata carries one left/right sample pair per word; m_tdata returns the
// resonator output pair, out = in + interpolated delayed output * feedback,
// saturated to 24 bits, one output word for each input word, in order.
// The cfg channel writes one register per handshake: cfg_index selects it,
// cfg_data carries the value. Each write starts a retune that keeps s_tready
// low while the delay is divided out one bit per cycle.
// Each word is read, interpolated, multiplied and written in turn, and a new
// word is taken only after the last one is written back, since these steps
// share each lane's single-write delay memory.
// After reset both delay memories are cleared one entry per cycle, which
// keeps s_tready low until every entry is zero; configuration writes are taken then.
// The output register holds a finished word while the receiver stalls; the
// next input word is still taken and worked on, and its result waits until
// the register frees up before it is written back to the delay memories.
// ============================================================================
`default_nettype none

module tunable_feedback_comb_resonator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream.
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [tfcr_pkg::TDATA_W-1:0]        s_tdata,  // left_in, right_in
    // Output stream.
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [tfcr_pkg::TDATA_W-1:0]        m_tdata,  // left_out, right_out
    // Configuration writes.
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [tfcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tfcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tfcr_pkg::tune_t      tune;
    tfcr_pkg::lane_ctrl_t lane_ctrl;

    logic                                    commit;
    logic                                    out_free;
    logic                                    m_tvalid_reg;
    logic [tfcr_pkg::TDATA_W-1:0]            m_tdata_reg;
    logic signed [tfcr_pkg::SAMPLE_BITS-1:0] left_in, right_in;
    logic signed [tfcr_pkg::SAMPLE_BITS-1:0] left_out, right_out;

    assign left_in  = $signed(s_tdata[tfcr_pkg::SAMPLE_BITS-1:0]);
    assign right_in = $signed(s_tdata[2*tfcr_pkg::SAMPLE_BITS-1:tfcr_pkg::SAMPLE_BITS]);

    // Register file and delay tuning.
    tfcr_tune u_tune (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tune      (tune)
    );

    // Sequencer shared by both lanes.
    tfcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .tune      (tune),
        .out_free  (out_free),
        .commit    (commit),
        .lane_ctrl (lane_ctrl)
    );

    // Channel lanes.
    tfcr_lane u_lane_left (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (left_in),
        .result (left_out)
    );

    tfcr_lane u_lane_right (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (right_in),
        .result (right_out)
    );

    // Output stage: merges both lanes into one word.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (commit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            m_tdata_reg <= tfcr_pkg::TDATA_W'({right_out, left_out});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tfcr_checker.sv =====
// ============================================================================
// tfcr_checker: port checks for the comb resonator
// Watches the stream and configuration ports and is bound to the top level.
// ============================================================================
`default_nettype none

module tfcr_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [tfcr_pkg::TDATA_W-1:0]      m_tdata,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready
);

    // A stalled output word stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed or dropped while stalled");

    // One word at a time: ready drops right after a word is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is still in work");

    // A fresh output word appears only after a matching input word was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("output word without matching input four cycles earlier");

    // A register write starts a retune that holds off input words and further writes.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
        else $error("input or config taken during retune");

endmodule

bind tunable_feedback_comb_resonator tfcr_checker u_tfcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== tb/sv/tunable_feedback_comb_resonator_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tunable_feedback_comb_resonator_tb: self-checking bench for the resonator
// Drives sample pairs and register writes with random idling and back
// pressure. A behavioral copy of the comb, with its own delay memories,
// predicts every output word. The checker compares each output word with the
// oldest prediction, one field at a time.
// ============================================================================

module tunable_feedback_comb_resonator_tb;

    import tfcr_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } pair_t;

    // The index past the last register; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam longint Q16_ONE = 65536;
    localparam sample_t PEAK_POS = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam sample_t PEAK_NEG = sample_t'(1 << (SAMPLE_BITS - 1));

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;   // left_in, right_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;   // left_out, right_out
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tunable_feedback_comb_resonator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies and the tuning they produce.
    logic [SR_W-1:0]   rate_q;
    logic [BASE_W-1:0] base_q;
    logic [NORM_W-1:0] norm_q;
    logic [STR_W-1:0]  strength_q;
    logic [FB_W-1:0]   gain_q;
    logic [STEP_W-1:0] step_q;
    logic [MOD_W-1:0]  mods_q;
    longint            held_dly;
    longint            eff_gain;

    // Delay memories of the comb copy, one per channel.
    sample_t echo_mem [2][MAX_DELAY];
    int      wr_ptr;

    pair_t expected_pairs [$];

    int  mismatches;
    int  words_checked;
    int  pairs_taken;
    int  regs_written;
    int  settings_used;
    bit  quiet;
    int  holds_asked;
    int  holds_served;
    int  hold_left;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Tuning: detune, frequency clamp and the Q14.8 delay.
    function automatic void retune();
        longint norm, depth, gain, step_amt, rate, freq, top_hz, low_hz, dly;
        norm     = norm_q;
        depth    = strength_q;
        gain     = gain_q;
        step_amt = step_q;
        rate     = rate_q;
        if (mods_q[MOD_STRENGTH])
        begin
            depth += step_amt;
            if (depth > Q16_ONE) depth = Q16_ONE;
        end
        if (mods_q[MOD_FEEDBACK]) gain += step_amt;
        if (gain > longint'(FB_LIMIT)) gain = longint'(FB_LIMIT);
        if (mods_q[MOD_OFFSET])
        begin
            norm += step_amt;
            if (norm > Q16_ONE) norm = Q16_ONE;
        end
        eff_gain = gain;
        freq = longint'(base_q) * Q16_ONE + ((2 * norm - Q16_ONE) * depth * 1000) / Q16_ONE;
        top_hz = rate * (Q16_ONE / 2) - Q16_ONE;
        low_hz = 20 * Q16_ONE;
        // The lower bound is applied last so that it wins when the bounds cross.
        if (freq > top_hz) freq = top_hz;
        if (freq < low_hz) freq = low_hz;
        dly = (rate * (longint'(1) << 24)) / freq;
        if (dly > longint'(MAX_DELAY) * 256 - 1) dly = longint'(MAX_DELAY) * 256 - 1;
        if (dly < 256) dly = 256;
        held_dly = dly;
    endfunction

    function automatic void load_reset_state();
        rate_q     = SR_RESET;
        base_q     = BASE_RESET;
        norm_q     = NORM_RESET;
        strength_q = '0;
        gain_q     = '0;
        step_q     = '0;
        mods_q     = '0;
        wr_ptr     = 0;
        for (int i = 0; i < MAX_DELAY; i++)
        begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        retune();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (cfg_reg_t'(idx))
            REG_SAMPLE_RATE:     rate_q     = data[SR_W-1:0];
            REG_BASE_FREQ:       base_q     = data[BASE_W-1:0];
            REG_OFFSET_NORM:     norm_q     = data[NORM_W-1:0];
            REG_OFFSET_STRENGTH: strength_q = data[STR_W-1:0];
            REG_FEEDBACK_GAIN:   gain_q     = data[FB_W-1:0];
            REG_STEP_VALUE:      step_q     = data[STEP_W-1:0];
            REG_MOD_ENABLES:     mods_q     = data[MOD_W-1:0];
            default:             return;
        endcase
        retune();
    endfunction

    // One channel of the comb: interpolated tap, feedback, saturation, store.
    function automatic sample_t resonate(int ch, longint dry);
        longint n, r, a, b, delayed, sum;
        n = held_dly >> FRAC_W;
        r = held_dly & 255;
        a = echo_mem[ch][(wr_ptr + MAX_DELAY - (n % MAX_DELAY)) % MAX_DELAY];
        b = echo_mem[ch][(wr_ptr + MAX_DELAY - ((n + 1) % MAX_DELAY)) % MAX_DELAY];
        delayed = (a * (256 - r) + b * r) / 256;
        sum = dry + (delayed * eff_gain) / Q16_ONE;
        if (sum > longint'(PEAK_POS)) sum = PEAK_POS;
        if (sum < longint'(PEAK_NEG)) sum = PEAK_NEG;
        echo_mem[ch][wr_ptr] = sample_t'(sum);
        return sample_t'(sum);
    endfunction

    function automatic void predict_pair(logic [TDATA_W-1:0] word);
        pair_t want;
        want.left  = resonate(0, longint'($signed(word[SAMPLE_BITS-1:0])));
        want.right = resonate(1, longint'($signed(word[2*SAMPLE_BITS-1:SAMPLE_BITS])));
        wr_ptr = (wr_ptr + 1) % MAX_DELAY;
        expected_pairs.push_back(want);
    endfunction

    function automatic void flag_field(string field, sample_t want, sample_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s differs: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function automatic void check_word(logic [TDATA_W-1:0] word);
        pair_t want;
        sample_t got_left, got_right;
        got_left  = word[SAMPLE_BITS-1:0];
        got_right = word[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (expected_pairs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: output word %0d/%0d with nothing expected",
                         $time, got_left, got_right);
            return;
        end
        want = expected_pairs.pop_front();
        words_checked++;
        if (got_left !== want.left) flag_field("left_out", want.left, got_left);
        if (got_right !== want.right) flag_field("right_out", want.right, got_right);
    endfunction

    // Handshake monitor: register writes, output checks and input predictions.
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            regs_written++;
            apply_reg(cfg_index, cfg_data);
        end
        if (m_tvalid && m_tready) check_word(m_tdata);
        if (s_tvalid && s_tready)
        begin
            pairs_taken++;
            predict_pair(s_tdata);
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end
        else
        begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 23);
        end
    end

    function automatic int reg_bits(logic [CFG_IDX_W-1:0] idx);
        case (cfg_reg_t'(idx))
            REG_SAMPLE_RATE:     return SR_W;
            REG_BASE_FREQ:       return BASE_W;
            REG_OFFSET_NORM:     return NORM_W;
            REG_OFFSET_STRENGTH: return STR_W;
            REG_FEEDBACK_GAIN:   return FB_W;
            REG_STEP_VALUE:      return STEP_W;
            REG_MOD_ENABLES:     return MOD_W;
            default:             return CFG_DATA_W;
        endcase
    endfunction

    // Writes one register; half the time the bits above its width carry junk.
    // The valid stays high so that writes can follow back to back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        mask = (CFG_DATA_W'(1) << reg_bits(idx)) - 1;
        junk = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (junk & ~mask) | (value & mask);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_settings(int rate, int base, int norm, int strength, int gain,
                                    int step_amt, int mods, bit poke_unused);
        if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_BASE_FREQ, base);
        write_reg(REG_OFFSET_NORM, norm);
        write_reg(REG_OFFSET_STRENGTH, strength);
        write_reg(REG_FEEDBACK_GAIN, gain);
        write_reg(REG_STEP_VALUE, step_amt);
        write_reg(REG_MOD_ENABLES, mods);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Offers one sample pair and returns at the edge that takes it.
    task automatic send_pair(sample_t left, sample_t right);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < 23) gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stops offering and waits for every predicted word to come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pairs.size() != 0) @(posedge clk);
    endtask

    function automatic int pick_q16();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 65535;
            2:       return 32768;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Full scale, small signals, or sparse impulses that let the comb ring.
    function automatic sample_t pick_sample(int style);
        longint v;
        case (style)
            0, 1:
                return sample_t'($urandom);
            2:
            begin
                v = $urandom_range(0, 131071);
                return sample_t'(v - 65536);
            end
            default:
            begin
                if ($urandom_range(0, 15) != 0) return '0;
                return $urandom_range(0, 1) ? PEAK_POS : PEAK_NEG;
            end
        endcase
    endfunction

    task automatic send_random_pairs(int count);
        int style;
        int phase_style;
        phase_style = $urandom_range(0, 3);
        for (int i = 0; i < count; i++)
        begin
            style = ($urandom_range(0, 3) != 0) ? phase_style : $urandom_range(0, 3);
            send_pair(pick_sample(style), pick_sample(style));
        end
    endtask

    task automatic program_random_settings();
        int rate, base, gain;
        case ($urandom_range(0, 9))
            0:       rate = $urandom_range(0, 19);
            1:       rate = (1 << SR_W) - 1;
            2:       rate = 192000;
            3:       rate = 8000;
            default: rate = $urandom_range(8000, 96000);
        endcase
        case ($urandom_range(0, 7))
            0:       base = $urandom_range(0, 20);
            1:       base = (1 << BASE_W) - 1;
            2:       base = 20000;
            default: base = $urandom_range(20, 20000);
        endcase
        case ($urandom_range(0, 5))
            0:       gain = 0;
            1:       gain = 62259;
            2:       gain = 65535;
            default: gain = $urandom_range(0, 65535);
        endcase
        program_settings(rate, base, pick_q16(), pick_q16(), gain, pick_q16(),
                         $urandom_range(0, 7), $urandom_range(0, 3) == 0);
    endtask

    // With the reset settings the feedback is off, so each word comes back as is.
    task automatic test_passthrough_defaults();
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair('0, -1);
        send_pair(-1, '0);
        send_pair(1, -2);
        send_pair(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
        wait_drained();
    endtask

    // Lowest rate and the widest pitch: the frequency clamps, the delay is two
    // samples and the largest feedback gain drives both channels into saturation.
    task automatic test_short_delay_saturation();
        program_settings(8000, (1 << BASE_W) - 1, 65535, 65535, 62259, 0, 0, 1'b0);
        for (int i = 0; i < 10; i++)
            send_pair(PEAK_POS, PEAK_NEG);
        wait_drained();
    endtask

    // A zero or tiny rate crosses the clamp bounds and the delay floors at one
    // sample; in the first setting every modulation is on and pushes past its limit.
    task automatic test_low_rate_clamp();
        program_settings(0, 440, 65535, 65535, 65535, 65535, 7, 1'b1);
        send_pair(PEAK_POS, -1000);
        send_pair(1000, PEAK_NEG);
        send_pair(PEAK_POS, PEAK_POS);
        wait_drained();
        program_settings(10, 0, 0, 65535, 30000, 0, 0, 1'b1);
        send_pair(PEAK_NEG, 123456);
        send_pair(-77, PEAK_POS);
        send_pair('0, '0);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            program_random_settings();
            quiet = (phase == 3);
            send_random_pairs(160);
            quiet = 1'b0;
            wait_drained();
        end
    endtask

    // The receiver holds off while the sender keeps offering at full rate.
    task automatic test_output_backpressure();
        program_settings(48000, 1000, 32768, 20000, 50000, 10000, 3, 1'b0);
        quiet = 1'b1;
        holds_asked++;
        send_random_pairs(60);
        quiet = 1'b0;
        wait_drained();
    endtask

    // The sender pauses until all words are out, then carries on with the memory.
    task automatic test_input_pause();
        send_random_pairs(40);
        wait_drained();
        send_random_pairs(40);
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet         = 1'b0;
        holds_asked   = 0;
        holds_served  = 0;
        hold_left     = 0;
        mismatches    = 0;
        words_checked = 0;
        pairs_taken   = 0;
        regs_written  = 0;
        settings_used = 1;
        load_reset_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_passthrough_defaults();
        test_short_delay_saturation();
        test_low_rate_clamp();
        test_random_settings();
        test_output_backpressure();
        test_input_pause();

        wait_drained();
        repeat (16) @(posedge clk);
        $display("Covered %0d sample pairs across %0d register settings (%0d writes).",
                 pairs_taken, settings_used, regs_written);
        $display("Compared %0d output words, %0d field mismatches.", words_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
